// File: hw/rtl/bpp_pkg.sv
// ----------------------------------------------------------------------------
// Boris particle push package
// Shared widths, register indexes, the divider stage record and the rounding
// and saturation helpers of the pusher datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bpp_pkg;

  localparam int unsigned WordW    = 32;
  localparam int unsigned DtW      = 31;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned ProdW    = 64;
  localparam int unsigned WideW    = 72;
  localparam int unsigned MagW     = 31;
  localparam int unsigned SqW      = 62;
  localparam int unsigned DenW     = 40;
  localparam int unsigned RemW     = 63;
  localparam int unsigned QuoW     = 32;
  localparam int unsigned DivSteps = 32;

  typedef logic signed [WordW-1:0] word_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [WideW-1:0] wide_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ROT_SCALE = 2'd0,
    CFG_TIME_STEP = 2'd1
  } cfg_reg_e;

  typedef struct {
    word_t             x[3];
    word_t             u[3];
    word_t             eq[3];
    word_t             uuh[3];
    logic              hneg[3];
    logic [DenW-1:0]   den;
    logic [RemW-1:0]   rem[3];
    logic [QuoW-1:0]   quo[3];
  } div_t;

  localparam wide_t WMaxX = wide_t'(64'sh0000_0000_7FFF_FFFF);
  localparam wide_t WMinX = -WMaxX - wide_t'(1);

  // Round to nearest with ties away from zero, done on the magnitude.
  function automatic wide_t rnd_shift(input wide_t a, input int unsigned n);
    logic [WideW-1:0] mag;
    logic             neg;
    neg = a[WideW-1];
    mag = neg ? WideW'(-a) : WideW'(a);
    mag = (mag + (WideW'(1) << (n - 1))) >> n;
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic word_t sat_word(input wide_t a);
    word_t r;
    if (a > WMaxX) begin
      r = word_t'(WMaxX);
    end else if (a < WMinX) begin
      r = word_t'(WMinX);
    end else begin
      r = word_t'(a);
    end
    return r;
  endfunction

  function automatic word_t sat_sym(input wide_t a);
    word_t r;
    if (a > WMaxX) begin
      r = word_t'(WMaxX);
    end else if (a < -WMaxX) begin
      r = word_t'(-WMaxX);
    end else begin
      r = word_t'(a);
    end
    return r;
  endfunction

  // One restoring division step on all three lanes.
  function automatic div_t div_step(input div_t d, input int unsigned k);
    div_t             r;
    logic [WideW-1:0] dsh;
    logic [WideW-1:0] remx;
    r = d;
    dsh = WideW'(d.den) << k;
    for (int i = 0; i < 3; i++) begin
      remx = WideW'(d.rem[i]);
      if (remx >= dsh) begin
        r.rem[i] = RemW'(remx - dsh);
        r.quo[i] = {d.quo[i][QuoW-2:0], 1'b1};
      end else begin
        r.quo[i] = {d.quo[i][QuoW-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/bpp_if.sv
// ----------------------------------------------------------------------------
// Boris particle push channels
// Valid/ready interfaces for the particle input beat and the result beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpp_in_if;
  logic               valid;
  logic               ready;
  bpp_pkg::word_t     pos_x;
  bpp_pkg::word_t     pos_y;
  bpp_pkg::word_t     pos_z;
  bpp_pkg::word_t     vel_x;
  bpp_pkg::word_t     vel_y;
  bpp_pkg::word_t     vel_z;
  bpp_pkg::word_t     efield_x;
  bpp_pkg::word_t     efield_y;
  bpp_pkg::word_t     efield_z;
  bpp_pkg::word_t     bfield_x;
  bpp_pkg::word_t     bfield_y;
  bpp_pkg::word_t     bfield_z;

  modport source (
    output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z,
    input  ready
  );
  modport sink (
    input  valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
           efield_x, efield_y, efield_z, bfield_x, bfield_y, bfield_z,
    output ready
  );
endinterface

interface bpp_out_if;
  logic               valid;
  logic               ready;
  bpp_pkg::word_t     new_pos_x;
  bpp_pkg::word_t     new_pos_y;
  bpp_pkg::word_t     new_pos_z;
  bpp_pkg::word_t     new_vel_x;
  bpp_pkg::word_t     new_vel_y;
  bpp_pkg::word_t     new_vel_z;

  modport source (
    output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    input  ready
  );
  modport sink (
    input  valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z,
    output ready
  );
endinterface

`default_nettype wire

// File: hw/rtl/boris_particle_push.sv
// ----------------------------------------------------------------------------
// Boris particle push
// Applies one Boris step to a particle: velocity update in E and B, then the
// position update over one time step, in saturating Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage: a particle beat (position, velocity, E and B) enters on in_if and
// the pushed position and velocity leave on out_if, one result per beat.
// The user must write the rotation factor and the time step through the cfg
// port only while the block is idle; the block does not enforce this. It
// accepts one beat every cycle while in_if.ready is high; each result
// passes four stages of products and rounding, one setup stage, 32 restoring
// division stages that form s one quotient bit each and five stages for the
// rotation, velocity and position. Reset clears both registers and all valid
// bits. When the receiver stalls the whole pipeline holds in place, so
// in_if.ready falls only while a finished result waits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module boris_particle_push (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [bpp_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [bpp_pkg::WordW-1:0]   cfg_wdata_i,
  bpp_in_if.sink                           in_if,
  bpp_out_if.source                        out_if
);

  bpp_pkg::word_t               rot_q;
  logic [bpp_pkg::DtW-1:0]      dt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q <= '0;
      dt_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpp_pkg::CFG_ROT_SCALE: rot_q <= $signed(cfg_wdata_i);
        bpp_pkg::CFG_TIME_STEP: dt_q  <= cfg_wdata_i[bpp_pkg::DtW-1:0];
        default: ;
      endcase
    end
  end

  logic pipe_en;
  logic o_vld_q;
  logic in_acc;

  assign pipe_en     = !o_vld_q || out_if.ready;
  assign in_if.ready = pipe_en;
  assign in_acc      = in_if.valid && pipe_en;

  bpp_pkg::word_t in_x[3], in_v[3], in_e[3], in_b[3];

  always_comb begin
    in_x[0] = in_if.pos_x;    in_x[1] = in_if.pos_y;    in_x[2] = in_if.pos_z;
    in_v[0] = in_if.vel_x;    in_v[1] = in_if.vel_y;    in_v[2] = in_if.vel_z;
    in_e[0] = in_if.efield_x; in_e[1] = in_if.efield_y; in_e[2] = in_if.efield_z;
    in_b[0] = in_if.bfield_x; in_b[1] = in_if.bfield_y; in_b[2] = in_if.bfield_z;
  end

  // Stage 1: field products with the rotation factor.
  logic           s1_vld_q;
  bpp_pkg::word_t s1_x_q[3], s1_v_q[3];
  bpp_pkg::prod_t s1_pe_q[3], s1_pb_q[3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        s1_x_q[i]  <= in_x[i];
        s1_v_q[i]  <= in_v[i];
        s1_pe_q[i] <= bpp_pkg::prod_t'(in_e[i]) * bpp_pkg::prod_t'(rot_q);
        s1_pb_q[i] <= bpp_pkg::prod_t'(in_b[i]) * bpp_pkg::prod_t'(rot_q);
      end
    end
  end

  // Stage 2: E*q' and h.
  logic           s2_vld_q;
  bpp_pkg::word_t s2_x_q[3], s2_v_q[3], s2_eq_q[3], s2_h_q[3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        s2_x_q[i]  <= s1_x_q[i];
        s2_v_q[i]  <= s1_v_q[i];
        s2_eq_q[i] <= bpp_pkg::sat_word(
                        bpp_pkg::rnd_shift(bpp_pkg::wide_t'(s1_pe_q[i]), 24));
        s2_h_q[i]  <= bpp_pkg::sat_sym(
                        bpp_pkg::rnd_shift(bpp_pkg::wide_t'(s1_pb_q[i]), 16));
      end
    end
  end

  // Stage 3: u and the squares of h.
  logic                     s3_vld_q;
  bpp_pkg::word_t           s3_x_q[3], s3_u_q[3], s3_eq_q[3], s3_h_q[3];
  logic [bpp_pkg::SqW-1:0]  s3_sq_q[3];
  logic [bpp_pkg::MagW-1:0] s2_hm[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s2_hm[i] = s2_h_q[i][bpp_pkg::WordW-1] ? bpp_pkg::MagW'(-s2_h_q[i])
                                              : s2_h_q[i][bpp_pkg::MagW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        s3_x_q[i]  <= s2_x_q[i];
        s3_eq_q[i] <= s2_eq_q[i];
        s3_h_q[i]  <= s2_h_q[i];
        s3_u_q[i]  <= bpp_pkg::sat_word(bpp_pkg::wide_t'(s2_v_q[i])
                                         + bpp_pkg::wide_t'(s2_eq_q[i]));
        s3_sq_q[i] <= bpp_pkg::SqW'(s2_hm[i]) * bpp_pkg::SqW'(s2_hm[i]);
      end
    end
  end

  // Stage 4: u x h products and the denominator.
  logic                     s4_vld_q;
  bpp_pkg::word_t           s4_x_q[3], s4_u_q[3], s4_eq_q[3], s4_h_q[3];
  bpp_pkg::prod_t           s4_pa_q[3], s4_pb_q[3];
  logic [bpp_pkg::DenW-1:0] s4_den_q;
  logic [bpp_pkg::ProdW-1:0] s3_sum;

  assign s3_sum = bpp_pkg::ProdW'(s3_sq_q[0]) + bpp_pkg::ProdW'(s3_sq_q[1])
                + bpp_pkg::ProdW'(s3_sq_q[2]) + (bpp_pkg::ProdW'(1) << 48);

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        s4_x_q[i]  <= s3_x_q[i];
        s4_u_q[i]  <= s3_u_q[i];
        s4_eq_q[i] <= s3_eq_q[i];
        s4_h_q[i]  <= s3_h_q[i];
        s4_pa_q[i] <= bpp_pkg::prod_t'(s3_u_q[(i+1)%3]) * bpp_pkg::prod_t'(s3_h_q[(i+2)%3]);
        s4_pb_q[i] <= bpp_pkg::prod_t'(s3_u_q[(i+2)%3]) * bpp_pkg::prod_t'(s3_h_q[(i+1)%3]);
      end
      s4_den_q <= s3_sum[bpp_pkg::ProdW-1:24];
    end
  end

  // Stage 5 and the divider: u + u x h and the quotient for s.
  logic                     dv_vld_q[bpp_pkg::DivSteps+1];
  bpp_pkg::div_t            dv_q[bpp_pkg::DivSteps+1];
  logic [bpp_pkg::MagW-1:0] s4_hm[3];
  bpp_pkg::wide_t           s4_uh[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s4_hm[i] = s4_h_q[i][bpp_pkg::WordW-1] ? bpp_pkg::MagW'(-s4_h_q[i])
                                              : s4_h_q[i][bpp_pkg::MagW-1:0];
      s4_uh[i] = bpp_pkg::rnd_shift(bpp_pkg::wide_t'(s4_pa_q[i])
                                    - bpp_pkg::wide_t'(s4_pb_q[i]), 24);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        dv_q[0].x[i]    <= s4_x_q[i];
        dv_q[0].u[i]    <= s4_u_q[i];
        dv_q[0].eq[i]   <= s4_eq_q[i];
        dv_q[0].uuh[i]  <= bpp_pkg::sat_word(bpp_pkg::wide_t'(s4_u_q[i]) + s4_uh[i]);
        dv_q[0].hneg[i] <= s4_h_q[i][bpp_pkg::WordW-1];
        dv_q[0].rem[i]  <= (bpp_pkg::RemW'(s4_hm[i]) << 31)
                           + bpp_pkg::RemW'(s4_den_q >> 1);
        dv_q[0].quo[i]  <= '0;
      end
      dv_q[0].den <= s4_den_q;
    end
  end

  for (genvar j = 0; j < bpp_pkg::DivSteps; j++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (pipe_en) begin
        dv_q[j+1] <= bpp_pkg::div_step(dv_q[j], bpp_pkg::DivSteps - 1 - j);
      end
    end
  end

  // R1: clamp and sign of s.
  logic           r1_vld_q;
  bpp_pkg::word_t r1_x_q[3], r1_u_q[3], r1_eq_q[3], r1_uuh_q[3], r1_s_q[3];
  bpp_pkg::word_t dv_sv[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dv_sv[i] = (dv_q[bpp_pkg::DivSteps].quo[i] > (bpp_pkg::QuoW'(1) << 30))
                 ? (bpp_pkg::word_t'(1) <<< 30)
                 : $signed(dv_q[bpp_pkg::DivSteps].quo[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        r1_x_q[i]   <= dv_q[bpp_pkg::DivSteps].x[i];
        r1_u_q[i]   <= dv_q[bpp_pkg::DivSteps].u[i];
        r1_eq_q[i]  <= dv_q[bpp_pkg::DivSteps].eq[i];
        r1_uuh_q[i] <= dv_q[bpp_pkg::DivSteps].uuh[i];
        r1_s_q[i]   <= dv_q[bpp_pkg::DivSteps].hneg[i] ? -dv_sv[i] : dv_sv[i];
      end
    end
  end

  // R2: (u + u x h) x s products.
  logic           r2_vld_q;
  bpp_pkg::word_t r2_x_q[3], r2_u_q[3], r2_eq_q[3];
  bpp_pkg::prod_t r2_pa_q[3], r2_pb_q[3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        r2_x_q[i]  <= r1_x_q[i];
        r2_u_q[i]  <= r1_u_q[i];
        r2_eq_q[i] <= r1_eq_q[i];
        r2_pa_q[i] <= bpp_pkg::prod_t'(r1_uuh_q[(i+1)%3]) * bpp_pkg::prod_t'(r1_s_q[(i+2)%3]);
        r2_pb_q[i] <= bpp_pkg::prod_t'(r1_uuh_q[(i+2)%3]) * bpp_pkg::prod_t'(r1_s_q[(i+1)%3]);
      end
    end
  end

  // R3: u' and the new velocity.
  logic           r3_vld_q;
  bpp_pkg::word_t r3_x_q[3], r3_vn_q[3];
  bpp_pkg::word_t r2_up[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r2_up[i] = bpp_pkg::sat_word(bpp_pkg::wide_t'(r2_u_q[i])
                   + bpp_pkg::rnd_shift(bpp_pkg::wide_t'(r2_pa_q[i])
                                        - bpp_pkg::wide_t'(r2_pb_q[i]), 30));
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        r3_x_q[i]  <= r2_x_q[i];
        r3_vn_q[i] <= bpp_pkg::sat_word(bpp_pkg::wide_t'(r2_up[i])
                                        + bpp_pkg::wide_t'(r2_eq_q[i]));
      end
    end
  end

  // R4: velocity times time step.
  logic           r4_vld_q;
  bpp_pkg::word_t r4_x_q[3], r4_vn_q[3];
  bpp_pkg::prod_t r4_pt_q[3];
  bpp_pkg::word_t dt_s;

  assign dt_s = $signed({1'b0, dt_q});

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        r4_x_q[i]  <= r3_x_q[i];
        r4_vn_q[i] <= r3_vn_q[i];
        r4_pt_q[i] <= bpp_pkg::prod_t'(r3_vn_q[i]) * bpp_pkg::prod_t'(dt_s);
      end
    end
  end

  // R5: new position into the output register.
  bpp_pkg::word_t o_x_q[3], o_vn_q[3];

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        o_vn_q[i] <= r4_vn_q[i];
        o_x_q[i]  <= bpp_pkg::sat_word(bpp_pkg::wide_t'(r4_x_q[i])
                       + bpp_pkg::rnd_shift(bpp_pkg::wide_t'(r4_pt_q[i]), 24));
      end
    end
  end

  // Valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      s4_vld_q <= 1'b0;
      for (int j = 0; j <= bpp_pkg::DivSteps; j++) begin
        dv_vld_q[j] <= 1'b0;
      end
      r1_vld_q <= 1'b0;
      r2_vld_q <= 1'b0;
      r3_vld_q <= 1'b0;
      r4_vld_q <= 1'b0;
      o_vld_q  <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_q    <= in_if.valid;
      s2_vld_q    <= s1_vld_q;
      s3_vld_q    <= s2_vld_q;
      s4_vld_q    <= s3_vld_q;
      dv_vld_q[0] <= s4_vld_q;
      for (int j = 0; j < bpp_pkg::DivSteps; j++) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
      r1_vld_q <= dv_vld_q[bpp_pkg::DivSteps];
      r2_vld_q <= r1_vld_q;
      r3_vld_q <= r2_vld_q;
      r4_vld_q <= r3_vld_q;
      o_vld_q  <= r4_vld_q;
    end
  end

  assign out_if.valid     = o_vld_q;
  assign out_if.new_pos_x = o_x_q[0];
  assign out_if.new_pos_y = o_x_q[1];
  assign out_if.new_pos_z = o_x_q[2];
  assign out_if.new_vel_x = o_vn_q[0];
  assign out_if.new_vel_y = o_vn_q[1];
  assign out_if.new_vel_z = o_vn_q[2];

  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_vld_q)
    else $error("Accepted beat did not enter the first stage.");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> (s1_vld_q == $past(s1_vld_q)) && (r4_vld_q == $past(r4_vld_q)))
    else $error("Pipeline moved while the output was stalled.");

  a_quo_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[bpp_pkg::DivSteps] |-> !dv_q[bpp_pkg::DivSteps].quo[0][bpp_pkg::QuoW-1]
                                 && !dv_q[bpp_pkg::DivSteps].quo[1][bpp_pkg::QuoW-1]
                                 && !dv_q[bpp_pkg::DivSteps].quo[2][bpp_pkg::QuoW-1])
    else $error("Quotient for s out of range.");

endmodule

`default_nettype wire

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Boris particle push testbench
// Drives particle beats with bursty gaps against a stalling result receiver,
// predicts each pushed position and velocity in fixed point and compares
// every result beat field by field across several register settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] f[12];
  } particle_t;

  typedef struct {
    logic signed [31:0] f[6];
  } pushed_t;

  localparam int Latency = 42;
  localparam int WatchLimit = 20000;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_we;
  logic [bpp_pkg::CfgIdxW-1:0]  cfg_idx;
  logic [bpp_pkg::WordW-1:0]    cfg_wdata;

  bpp_in_if  in_ch ();
  bpp_out_if out_ch ();

  boris_particle_push u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_if       (in_ch.sink),
    .out_if      (out_ch.source)
  );

  logic signed [63:0] rot_scale;
  logic signed [63:0] step_len;
  pushed_t            pending_q[$];
  int                 fail_cnt;
  int                 idle_cycles;
  int                 burst_left;
  bit                 hold_off;
  bit                 rx_noise;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic signed [63:0] rnd_sh(input logic signed [63:0] a, input int n);
    logic [63:0] m;
    m = a < 0 ? 64'(-a) : 64'(a);
    m = (m + (64'd1 << (n - 1))) >> n;
    return a < 0 ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] a,
                                                input logic signed [63:0] lo);
    logic signed [63:0] hi;
    hi = 64'sh7FFF_FFFF;
    return a < lo ? lo : (a > hi ? hi : a);
  endfunction

  function automatic pushed_t boris_push(input particle_t p);
    pushed_t            r;
    logic signed [63:0] x[3], v[3], e[3], b[3], eq[3], h[3], s[3], u[3];
    logic signed [63:0] uh[3], uuh[3], rot[3], vn[3], up;
    logic signed [63:0] wmin;
    logic [63:0]        hsq, den, m, q;
    wmin = -64'sh8000_0000;
    hsq = 0;
    for (int i = 0; i < 3; i++) begin
      x[i] = p.f[i];
      v[i] = p.f[3+i];
      e[i] = p.f[6+i];
      b[i] = p.f[9+i];
      eq[i] = clamp(rnd_sh(e[i] * rot_scale, 24), wmin);
      h[i] = clamp(rnd_sh(b[i] * rot_scale, 16), -64'sh7FFF_FFFF);
      m = h[i] < 0 ? 64'(-h[i]) : 64'(h[i]);
      hsq += m * m;
    end
    den = (hsq + (64'd1 << 48)) >> 24;
    for (int i = 0; i < 3; i++) begin
      m = h[i] < 0 ? 64'(-h[i]) : 64'(h[i]);
      q = ((m << 31) + den / 2) / den;
      if (q > (64'd1 << 30)) q = 64'd1 << 30;
      s[i] = h[i] < 0 ? -$signed(q) : $signed(q);
      u[i] = clamp(v[i] + eq[i], wmin);
    end
    for (int i = 0; i < 3; i++) begin
      uh[i] = rnd_sh(u[(i+1)%3] * h[(i+2)%3] - u[(i+2)%3] * h[(i+1)%3], 24);
    end
    for (int i = 0; i < 3; i++) uuh[i] = clamp(u[i] + uh[i], wmin);
    for (int i = 0; i < 3; i++) begin
      rot[i] = rnd_sh(uuh[(i+1)%3] * s[(i+2)%3] - uuh[(i+2)%3] * s[(i+1)%3], 30);
    end
    for (int i = 0; i < 3; i++) begin
      up = clamp(u[i] + rot[i], wmin);
      vn[i] = clamp(up + eq[i], wmin);
      r.f[3+i] = vn[i][31:0];
      r.f[i] = 32'(clamp(x[i] + rnd_sh(vn[i] * step_len, 24), wmin));
    end
    return r;
  endfunction

  task automatic write_reg(input bpp_pkg::cfg_reg_e idx, input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == bpp_pkg::CFG_ROT_SCALE) rot_scale = $signed(val);
    else step_len = {33'd0, val[30:0]};
    @(negedge clk);
  endtask

  task automatic write_stray(input logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= 2'd3;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_particle(input particle_t p);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.pos_x <= p.f[0];    in_ch.pos_y <= p.f[1];    in_ch.pos_z <= p.f[2];
    in_ch.vel_x <= p.f[3];    in_ch.vel_y <= p.f[4];    in_ch.vel_z <= p.f[5];
    in_ch.efield_x <= p.f[6]; in_ch.efield_y <= p.f[7]; in_ch.efield_z <= p.f[8];
    in_ch.bfield_x <= p.f[9]; in_ch.bfield_y <= p.f[10]; in_ch.bfield_z <= p.f[11];
    do @(posedge clk); while (!in_ch.ready);
    pending_q.push_back(boris_push(p));
    @(negedge clk);
  endtask

  task automatic drain;
    in_ch.valid <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic logic [31:0] rand_word(input int mode);
    case (mode)
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8) << 16;
      3: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return $urandom;
    endcase
  endfunction

  function automatic particle_t rand_particle(input bit wild);
    particle_t p;
    for (int i = 0; i < 12; i++) begin
      p.f[i] = wild ? rand_word($urandom_range(0, 4)) : rand_word($urandom_range(3, 4));
      if (!wild && i >= 6 && $urandom_range(0, 1)) p.f[i] = rand_word(3);
    end
    return p;
  endfunction

  task automatic test_zero_registers;
    particle_t p;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 12; i++) p.f[i] = k[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (k > 1) p = rand_particle(1'b0);
      send_particle(p);
    end
    drain();
  endtask

  task automatic test_extremes;
    particle_t p;
    write_reg(bpp_pkg::CFG_ROT_SCALE, 32'h7FFF_FFFF);
    write_reg(bpp_pkg::CFG_TIME_STEP, 32'hFFFF_FFFF);
    for (int k = 0; k < 8; k++) begin
      for (int i = 0; i < 12; i++) p.f[i] = rand_word(k % 2);
      if (k >= 4) p = rand_particle(1'b1);
      send_particle(p);
    end
    drain();
    write_reg(bpp_pkg::CFG_ROT_SCALE, 32'h8000_0000);
    write_stray(32'h0);
    for (int k = 0; k < 6; k++) send_particle(rand_particle(1'b1));
    drain();
  endtask

  task automatic test_random_settings;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(bpp_pkg::CFG_ROT_SCALE, ph == 0 ? 32'h0100_0000 : $urandom);
      write_reg(bpp_pkg::CFG_TIME_STEP, ph == 1 ? 32'h0 : $urandom);
      if (ph >= 2 && ph < 6) begin
        write_reg(bpp_pkg::CFG_ROT_SCALE,
                  32'($signed($urandom_range(0, 1 << 25)) - (1 << 24)));
      end
      if (ph == 3) hold_off = 1'b1;
      for (int k = 0; k < 65; k++) send_particle(rand_particle($urandom_range(0, 4) == 0));
      drain();
    end
  endtask

  always @(posedge clk) begin
    pushed_t got;
    pushed_t exp_r;
    if (out_ch.valid && out_ch.ready) begin
      got.f[0] = out_ch.new_pos_x; got.f[1] = out_ch.new_pos_y;
      got.f[2] = out_ch.new_pos_z; got.f[3] = out_ch.new_vel_x;
      got.f[4] = out_ch.new_vel_y; got.f[5] = out_ch.new_vel_z;
      if (pending_q.size() == 0) begin
        $error("unexpected result beat");
        fail_cnt++;
      end else begin
        exp_r = pending_q.pop_front();
        for (int i = 0; i < 6; i++) begin
          if (got.f[i] !== exp_r.f[i]) begin
            $error("%s: expected %h actual %h",
                   i == 0 ? "new_pos_x" : i == 1 ? "new_pos_y" : i == 2 ? "new_pos_z" :
                   i == 3 ? "new_vel_x" : i == 4 ? "new_vel_y" : "new_vel_z",
                   exp_r.f[i], got.f[i]);
            fail_cnt++;
          end
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) begin
      hold_off = 1'b0;
      out_ch.ready <= 1'b0;
      repeat (200) @(negedge clk);
    end else begin
      if ($urandom_range(0, 49) == 0) rx_noise = ~rx_noise;
      out_ch.ready <= rx_noise ? ($urandom_range(0, 2) != 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > WatchLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.pos_x = '0;    in_ch.pos_y = '0;    in_ch.pos_z = '0;
    in_ch.vel_x = '0;    in_ch.vel_y = '0;    in_ch.vel_z = '0;
    in_ch.efield_x = '0; in_ch.efield_y = '0; in_ch.efield_z = '0;
    in_ch.bfield_x = '0; in_ch.bfield_y = '0; in_ch.bfield_z = '0;
    rot_scale = 0;
    step_len = 0;
    fail_cnt = 0;
    idle_cycles = 0;
    burst_left = 0;
    hold_off = 1'b0;
    rx_noise = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_zero_registers();
    test_extremes();
    test_random_settings();
    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: boris_particle_push.f
hw/rtl/bpp_pkg.sv
hw/rtl/bpp_if.sv
hw/rtl/boris_particle_push.sv
dv/tb.sv
